// ===== sv/kpc_pkg.sv =====
package kpc_pkg;

    // Square geometry
    localparam int SIDE   = 6;
    localparam int CELLS  = SIDE * SIDE;
    localparam int SLOT_W = $clog2(CELLS + 1);
    localparam int DIG_W  = $clog2(SIDE);

    // Operation codes carried by an input transaction
    localparam logic [1:0] OP_KEY  = 2'd0;
    localparam logic [1:0] OP_DONE = 2'd1;
    localparam logic [1:0] OP_ENC  = 2'd2;
    localparam logic [1:0] OP_DEC  = 2'd3;

    // Result status codes
    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_MISS  = 2'd1;
    localparam logic [1:0] ST_RANGE = 2'd2;

    // Character constants
    localparam logic [7:0] CH_A     = 8'h41;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_TOP   = CH_ZERO + 8'(SIDE);
    localparam int         N_LETTERS = 26;

    // Probe token that walks the row of cells, one cell per cycle
    typedef struct packed {
        logic             busy;
        logic             rd;     // 1: read by row/col, 0: find symbol
        logic [7:0]       sym;
        logic             hit;
        logic [DIG_W-1:0] row;
        logic [DIG_W-1:0] col;
        logic [7:0]       data;
    } t_probe;

    // Write port broadcast to all cells
    typedef struct packed {
        logic              en;
        logic [SLOT_W-1:0] slot;
        logic [7:0]        data;
    } t_wr;

    // One result transaction
    typedef struct packed {
        logic [7:0] out_char;
        logic [1:0] status;
        logic       last;
    } t_res;

    // Fill order for key completion: A-Z then 0-9
    function automatic logic [7:0] fill_sym(input logic [SLOT_W-1:0] idx);
        logic [7:0] r;
        if (idx < SLOT_W'(N_LETTERS)) begin
            r = CH_A + 8'(idx);
        end else begin
            r = CH_ZERO + 8'(idx - SLOT_W'(N_LETTERS));
        end
        return r;
    endfunction

endpackage

// ===== sv/kpc_cell.sv =====
module kpc_cell (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic [kpc_pkg::SLOT_W-1:0] i_slot,
    input  logic [kpc_pkg::DIG_W-1:0]  i_row,
    input  logic [kpc_pkg::DIG_W-1:0]  i_col,
    input  logic [kpc_pkg::SLOT_W-1:0] i_fill,
    input  kpc_pkg::t_wr               i_wr,
    input  kpc_pkg::t_probe            i_probe,
    output kpc_pkg::t_probe            o_probe
);
    import kpc_pkg::*;

    logic [7:0] r_entry;
    t_probe     r_probe;
    t_probe     n_probe;
    logic       w_valid;

    // Entry is live only below the fill count
    assign w_valid = (i_slot < i_fill);

    // First live match claims the probe
    always_comb begin
        n_probe = i_probe;
        if (i_probe.busy && !i_probe.hit && w_valid) begin
            if (i_probe.rd) begin
                if (i_probe.row == i_row && i_probe.col == i_col) begin
                    n_probe.hit  = 1'b1;
                    n_probe.data = r_entry;
                end
            end else if (r_entry == i_probe.sym) begin
                n_probe.hit = 1'b1;
                n_probe.row = i_row;
                n_probe.col = i_col;
            end
        end
    end

    // Entry storage
    always_ff @(posedge i_clk) begin
        if (i_wr.en && i_wr.slot == i_slot) begin
            r_entry <= i_wr.data;
        end
    end

    // Hand the probe to the next cell
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_probe.busy <= 1'b0;
        end else begin
            r_probe <= n_probe;
        end
    end

    assign o_probe = r_probe;

endmodule

// ===== sv/keyed_polybius_cipher.sv =====
// Keyed 6x6 Polybius square.
// Input channel: i_valid/o_stall with i_op and i_ch. A transaction is taken when
// i_valid is high and o_stall is low. Key characters build the square, key done
// fills the rest with A-Z then 0-9, encrypt emits row and column digits, decrypt
// consumes digit pairs and emits the square entry.
// Output channel: o_valid/i_stall with o_out_char, o_status, o_last.
// The square lives in a row of 36 cells; every lookup is a probe token that moves
// one cell per clock through the whole row. Steps per item:
//   key character: one probe through the row, no result
//   key done: 36 fill probes, one per symbol of A-Z and 0-9, no result
//   encrypt/decrypt lookup: one probe, the result loaded once it leaves the row,
//     the second encrypt digit once the output register frees up again
//   space, bad digit: result loaded with no probe
//   first decrypt digit: held for the pair, no result
// One item is in work at a time; o_stall is high while an item is in work.
// When i_stall holds, the result register holds and the block waits for it.
// Reset (synchronous, i_rst_n low) empties the square, drops any pending
// decrypt digit and clears o_valid.
module keyed_polybius_cipher (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    input  logic [1:0] i_op,
    input  logic [7:0] i_ch,
    output logic       o_stall,
    output logic       o_valid,
    output logic [7:0] o_out_char,
    output logic [1:0] o_status,
    output logic       o_last,
    input  logic       i_stall
);
    import kpc_pkg::*;

    typedef enum logic [1:0] {S_IDLE, S_RUN, S_EMIT} t_state;

    t_state            r_state;
    logic [1:0]        r_kind;
    logic [SLOT_W-1:0] r_fill;
    logic              r_ready;
    logic [DIG_W-1:0]  r_pend_digit;
    logic              r_pend_valid;
    logic [SLOT_W-1:0] r_icnt;
    logic [SLOT_W-1:0] r_xcnt;
    t_probe            r_inj;
    t_res              r_res0;
    t_res              r_res1;
    logic              r_two;
    logic              r_o_valid;
    t_res              r_out;

    t_probe            w_chain [CELLS+1];
    t_probe            w_exit;
    t_wr               w_wr;
    logic              w_in_acc;
    logic              w_out_free;
    logic [DIG_W-1:0]  w_digit;

    // Row of cells
    assign w_chain[0] = r_inj;
    for (genvar k = 0; k < CELLS; k++) begin : g_cell
        kpc_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_slot  (SLOT_W'(k)),
            .i_row   (DIG_W'(k / SIDE)),
            .i_col   (DIG_W'(k % SIDE)),
            .i_fill  (r_fill),
            .i_wr    (w_wr),
            .i_probe (w_chain[k]),
            .o_probe (w_chain[k+1])
        );
    end
    assign w_exit = w_chain[CELLS];

    // Append an unmatched key or fill symbol when a slot is free
    always_comb begin
        w_wr.en   = (r_state == S_RUN) && w_exit.busy && !w_exit.hit && !w_exit.rd &&
                    (r_kind == OP_KEY || r_kind == OP_DONE) &&
                    (r_fill < SLOT_W'(CELLS));
        w_wr.slot = r_fill;
        w_wr.data = w_exit.sym;
    end

    assign o_stall    = (r_state != S_IDLE);
    assign w_in_acc   = i_valid && !o_stall;
    assign w_out_free = !r_o_valid || !i_stall;
    assign w_digit    = DIG_W'(i_ch - CH_ZERO);

    // Control sequencer and result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_kind       <= OP_KEY;
            r_fill       <= '0;
            r_ready      <= 1'b0;
            r_pend_digit <= '0;
            r_pend_valid <= 1'b0;
            r_icnt       <= '0;
            r_xcnt       <= '0;
            r_inj.busy   <= 1'b0;
            r_two        <= 1'b0;
            r_o_valid    <= 1'b0;
        end else begin
            // Drop a taken result; in S_EMIT a new one may load instead
            if (r_o_valid && !i_stall && r_state != S_EMIT) begin
                r_o_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (w_in_acc) begin
                        r_kind     <= i_op;
                        r_inj.rd   <= (i_op == OP_DEC);
                        r_inj.sym  <= i_ch;
                        r_inj.hit  <= 1'b0;
                        r_inj.data <= '0;
                        r_two      <= 1'b0;
                        case (i_op)
                            OP_KEY: begin
                                if (r_ready) begin
                                    r_ready <= 1'b0;
                                    r_fill  <= '0;
                                end
                                r_inj.busy <= 1'b1;
                                r_state    <= S_RUN;
                            end
                            OP_DONE: begin
                                r_icnt  <= '0;
                                r_xcnt  <= '0;
                                r_state <= S_RUN;
                            end
                            OP_ENC: begin
                                if (i_ch == CH_SPACE) begin
                                    r_res0  <= '{CH_SPACE, ST_OK, 1'b1};
                                    r_state <= S_EMIT;
                                end else begin
                                    r_inj.busy <= 1'b1;
                                    r_state    <= S_RUN;
                                end
                            end
                            default: begin
                                if (i_ch == CH_SPACE) begin
                                    r_pend_valid <= 1'b0;
                                    r_pend_digit <= '0;
                                    r_res0       <= '{CH_SPACE, ST_OK, 1'b1};
                                    r_state      <= S_EMIT;
                                end else if (i_ch < CH_ZERO || i_ch >= CH_TOP) begin
                                    r_pend_valid <= 1'b0;
                                    r_pend_digit <= '0;
                                    r_res0       <= '{8'h00, ST_RANGE, 1'b1};
                                    r_state      <= S_EMIT;
                                end else if (!r_pend_valid) begin
                                    r_pend_digit <= w_digit;
                                    r_pend_valid <= 1'b1;
                                end else begin
                                    r_pend_valid <= 1'b0;
                                    r_pend_digit <= '0;
                                    r_inj.busy   <= 1'b1;
                                    r_inj.row    <= r_pend_digit;
                                    r_inj.col    <= w_digit;
                                    r_state      <= S_RUN;
                                end
                            end
                        endcase
                    end
                end
                S_RUN: begin
                    // Stream fill symbols into the row, one per cycle
                    if (r_kind == OP_DONE && r_icnt < SLOT_W'(CELLS)) begin
                        r_inj.busy <= 1'b1;
                        r_inj.rd   <= 1'b0;
                        r_inj.sym  <= fill_sym(r_icnt);
                        r_inj.hit  <= 1'b0;
                        r_icnt     <= r_icnt + 1'b1;
                    end else begin
                        r_inj.busy <= 1'b0;
                    end
                    if (w_exit.busy) begin
                        if (w_wr.en) begin
                            r_fill <= r_fill + 1'b1;
                        end
                        case (r_kind)
                            OP_KEY: begin
                                r_state <= S_IDLE;
                            end
                            OP_DONE: begin
                                r_xcnt <= r_xcnt + 1'b1;
                                if (r_xcnt == SLOT_W'(CELLS - 1)) begin
                                    r_ready <= 1'b1;
                                    r_state <= S_IDLE;
                                end
                            end
                            OP_ENC: begin
                                if (w_exit.hit) begin
                                    r_res0 <= '{CH_ZERO + 8'(w_exit.row), ST_OK, 1'b0};
                                    r_res1 <= '{CH_ZERO + 8'(w_exit.col), ST_OK, 1'b1};
                                    r_two  <= 1'b1;
                                end else begin
                                    r_res0 <= '{8'h00, ST_MISS, 1'b1};
                                end
                                r_state <= S_EMIT;
                            end
                            default: begin
                                if (w_exit.hit) begin
                                    r_res0 <= '{w_exit.data, ST_OK, 1'b1};
                                end else begin
                                    r_res0 <= '{8'h00, ST_MISS, 1'b1};
                                end
                                r_state <= S_EMIT;
                            end
                        endcase
                    end
                end
                S_EMIT: begin
                    // Load results into the output register as it frees up
                    if (w_out_free) begin
                        r_out     <= r_res0;
                        r_o_valid <= 1'b1;
                        if (r_two) begin
                            r_res0 <= r_res1;
                            r_two  <= 1'b0;
                        end else begin
                            r_state <= S_IDLE;
                        end
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_valid    = r_o_valid;
    assign o_out_char = r_out.out_char;
    assign o_status   = r_out.status;
    assign o_last     = r_out.last;

`ifndef SYNTHESIS
    // Fill count never passes the square size
    a_fill_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fill <= SLOT_W'(CELLS))
        else $error("fill count beyond square size");

    // A completed key always leaves a full square
    a_ready_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ready |-> r_fill == SLOT_W'(CELLS))
        else $error("square ready but not full");

    // Probes only leave the row while a lookup is in work
    a_exit_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_exit.busy |-> r_state == S_RUN)
        else $error("probe left the row outside a lookup");

    // Fill probes never outnumber those issued
    a_fill_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_exit.busy && r_state == S_RUN && r_kind == OP_DONE) |-> r_xcnt < r_icnt)
        else $error("fill probe exit without issue");
`endif

endmodule

// ===== tb/tb.sv =====
`timescale 1ns / 1ps

module tb;
    import kpc_pkg::*;

    localparam int LIMIT      = 1_000_000;  // cycle budget for the whole run
    localparam int DRAIN      = 100;        // drain after the last expected output, covers a trailing key done
    localparam int N_RANDOM   = 750;
    localparam int HOLD_AT    = 200;        // transactions taken before the long hold
    localparam int HOLD_LEN   = 400;

    typedef struct packed {
        logic [1:0] op;
        logic [7:0] ch;
    } t_cipher_item;

    // Receiver stall patterns
    typedef enum logic [1:0] {RX_FLOW, RX_LIGHT, RX_HEAVY, RX_BEAT} t_rx_mode;

    logic       i_clk   = 1'b0;
    logic       i_rst_n = 1'b0;
    logic       i_valid = 1'b0;
    logic [1:0] i_op    = OP_KEY;
    logic [7:0] i_ch    = 8'h00;
    logic       i_stall = 1'b0;
    logic       o_stall;
    logic       o_valid;
    logic [7:0] o_out_char;
    logic [1:0] o_status;
    logic       o_last;

    keyed_polybius_cipher i_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (i_valid),
        .i_op       (i_op),
        .i_ch       (i_ch),
        .o_stall    (o_stall),
        .o_valid    (o_valid),
        .o_out_char (o_out_char),
        .o_status   (o_status),
        .o_last     (o_last),
        .i_stall    (i_stall)
    );

    always #1 i_clk = ~i_clk;

    // Stimulus and expected output characters
    t_cipher_item send_q[$];
    t_res         cipher_results[$];

    // Shadow of the square and the decrypt pair state
    logic [7:0] sq_sym [CELLS];
    logic [5:0] sq_fill  = '0;
    logic       sq_ready = 1'b0;
    logic [2:0] pair_dig = '0;
    logic       pair_ok  = 1'b0;

    int mismatches = 0;
    int n_taken    = 0;
    int n_results  = 0;
    int cycle_cnt  = 0;
    int n_pairs = 0, n_plain = 0, n_space = 0, n_miss = 0, n_range = 0;
    int n_rekey = 0, n_dropped = 0;
    logic in_taken = 1'b0;

    // Sender and receiver pacing
    int       burst_left = 8;
    int       gap_left   = 0;
    int       hold_left  = 0;
    logic     hold_done  = 1'b0;
    t_rx_mode rx_mode    = RX_FLOW;
    int       rx_left    = 0;
    int       rx_phase   = 0;

    // Fill order: A-Z then 0-9
    function automatic logic [7:0] alnum(input int k);
        return (k < N_LETTERS) ? CH_A + 8'(k) : CH_ZERO + 8'(k - N_LETTERS);
    endfunction

    function automatic int slot_of(input logic [7:0] c);
        for (int i = 0; i < int'(sq_fill); i++) begin
            if (sq_sym[i] == c) return i;
        end
        return -1;
    endfunction

    function automatic void queue_result(input logic [7:0] c, input logic [1:0] st,
                                         input logic last);
        t_res r;
        r.out_char = c;
        r.status   = st;
        r.last     = last;
        cipher_results.push_back(r);
        if (st == ST_MISS) n_miss++;
        if (st == ST_RANGE) n_range++;
        if (st == ST_OK && c == CH_SPACE) n_space++;
    endfunction

    function automatic void add_symbol(input logic [7:0] c);
        if (sq_fill < CELLS && slot_of(c) < 0) begin
            sq_sym[sq_fill] = c;
            sq_fill++;
        end
    endfunction

    // Work out the output characters of one taken transaction
    task automatic cipher_predict(input logic [1:0] op, input logic [7:0] ch);
        int slot;
        int idx;
        case (op)
            OP_KEY: begin
                // a key character after key done starts a new key
                if (sq_ready) begin
                    sq_ready = 1'b0;
                    sq_fill  = '0;
                    n_rekey++;
                end
                if (sq_fill == CELLS) n_dropped++;
                add_symbol(ch);
            end
            OP_DONE: begin
                for (int k = 0; k < CELLS; k++) add_symbol(alnum(k));
                sq_ready = 1'b1;
            end
            OP_ENC: begin
                if (ch == CH_SPACE) begin
                    queue_result(CH_SPACE, ST_OK, 1'b1);
                end else begin
                    slot = slot_of(ch);
                    if (slot < 0) begin
                        queue_result(8'h00, ST_MISS, 1'b1);
                    end else begin
                        queue_result(CH_ZERO + 8'(slot / SIDE), ST_OK, 1'b0);
                        queue_result(CH_ZERO + 8'(slot % SIDE), ST_OK, 1'b1);
                        n_pairs++;
                    end
                end
            end
            default: begin
                if (ch == CH_SPACE) begin
                    pair_ok  = 1'b0;
                    pair_dig = '0;
                    queue_result(CH_SPACE, ST_OK, 1'b1);
                end else if (ch < CH_ZERO || ch >= CH_TOP) begin
                    pair_ok  = 1'b0;
                    pair_dig = '0;
                    queue_result(8'h00, ST_RANGE, 1'b1);
                end else if (!pair_ok) begin
                    pair_dig = 3'(ch - CH_ZERO);
                    pair_ok  = 1'b1;
                end else begin
                    idx = int'(pair_dig) * SIDE + int'(ch - CH_ZERO);
                    pair_ok  = 1'b0;
                    pair_dig = '0;
                    if (idx < int'(sq_fill)) begin
                        queue_result(sq_sym[idx], ST_OK, 1'b1);
                        n_plain++;
                    end else begin
                        queue_result(8'h00, ST_MISS, 1'b1);
                    end
                end
            end
        endcase
    endtask

    task automatic report_mismatch(input string msg);
        $display("ERROR @%0t: %s", $time, msg);
        mismatches++;
    endtask

    task automatic add_item(input logic [1:0] op, input logic [7:0] ch);
        t_cipher_item it;
        it.op = op;
        it.ch = ch;
        send_q.push_back(it);
    endtask

    // One piece of message text: encrypt symbols, decrypt pairs, spaces and junk
    task automatic add_text_step();
        int r;
        r = $urandom_range(0, 99);
        if (r < 45) begin
            add_item(OP_ENC, alnum($urandom_range(0, CELLS - 1)));
        end else if (r < 53) begin
            add_item(OP_ENC, CH_SPACE);
        end else if (r < 58) begin
            add_item(OP_ENC, 8'($urandom_range(0, 255)));
        end else if (r < 88) begin
            add_item(OP_DEC, CH_ZERO + 8'($urandom_range(0, SIDE - 1)));
            add_item(OP_DEC, CH_ZERO + 8'($urandom_range(0, SIDE - 1)));
        end else if (r < 93) begin
            add_item(OP_DEC, CH_SPACE);
        end else if (r < 97) begin
            add_item(OP_DEC, 8'($urandom_range(0, 255)));
        end else begin
            add_item(OP_DEC, CH_ZERO + 8'($urandom_range(0, SIDE - 1)));
        end
    endtask

    // Key of n random characters; long keys can overflow the square
    task automatic add_key(input int n);
        repeat (n) begin
            if ($urandom_range(0, 4) == 0) add_item(OP_KEY, 8'($urandom_range(0, 255)));
            else add_item(OP_KEY, alnum($urandom_range(0, CELLS - 1)));
        end
    endtask

    // Monitor: check output transactions, then predict from the input transaction
    always @(posedge i_clk) begin : mon_proc
        t_res want;
        if (i_rst_n) begin
            if (o_valid && !i_stall) begin
                n_results++;
                if (cipher_results.size() == 0) begin
                    report_mismatch($sformatf("char %02h status %0d with nothing expected",
                                              o_out_char, o_status));
                end else begin
                    want = cipher_results.pop_front();
                    if (o_out_char !== want.out_char)
                        report_mismatch($sformatf("out_char %02h, expected %02h",
                                                  o_out_char, want.out_char));
                    if (o_status !== want.status)
                        report_mismatch($sformatf("status %0d, expected %0d",
                                                  o_status, want.status));
                    if (o_last !== want.last)
                        report_mismatch($sformatf("last %0b, expected %0b",
                                                  o_last, want.last));
                end
            end
            if (i_valid && !o_stall) begin
                cipher_predict(i_op, i_ch);
                n_taken++;
            end
        end
        in_taken  <= i_rst_n && i_valid && !o_stall;
        cycle_cnt <= cycle_cnt + 1;
    end

    // Driver: bursts of transactions with random gaps between them
    always @(negedge i_clk) begin : drive_proc
        t_cipher_item it;
        logic         offer;
        offer = i_valid && !in_taken;
        if (i_rst_n && !offer) begin
            if (gap_left > 0) begin
                gap_left--;
            end else if (send_q.size() > 0) begin
                it    = send_q.pop_front();
                offer = 1'b1;
                i_op <= it.op;
                i_ch <= it.ch;
                if (burst_left > 1) begin
                    burst_left--;
                end else begin
                    burst_left = $urandom_range(1, 30);
                    gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
                end
            end
        end
        i_valid <= offer;
    end

    // Receiver: changing stall patterns plus one long hold
    always @(negedge i_clk) begin : recv_proc
        logic stall_n;
        stall_n = 1'b0;
        if (hold_left > 0) begin
            hold_left--;
            stall_n = 1'b1;
        end else if (!hold_done && n_taken >= HOLD_AT) begin
            hold_done = 1'b1;
            hold_left = HOLD_LEN - 1;
            stall_n   = 1'b1;
        end else if (i_rst_n) begin
            if (rx_left == 0) begin
                rx_mode = t_rx_mode'($urandom_range(0, 3));
                rx_left = $urandom_range(50, 400);
            end
            rx_left--;
            rx_phase++;
            case (rx_mode)
                RX_FLOW:  stall_n = 1'b0;
                RX_LIGHT: stall_n = ($urandom_range(0, 99) < 30);
                RX_HEAVY: stall_n = ($urandom_range(0, 99) < 75);
                default:  stall_n = ((rx_phase % 5) < 2);
            endcase
        end
        i_stall <= stall_n;
    end

    // Watchdog
    initial begin
        while (cycle_cnt < LIMIT) @(posedge i_clk);
        $display("Regression FAIL");
        $finish;
    end

    initial begin
        int n_directed;
        int r;

        // Lookups on an empty square
        add_item(OP_ENC, CH_A);
        add_item(OP_DEC, CH_ZERO);
        add_item(OP_DEC, CH_ZERO);
        // Key with a duplicate and non-alphanumeric bytes, then fill
        add_item(OP_KEY, "K");
        add_item(OP_KEY, "E");
        add_item(OP_KEY, "Y");
        add_item(OP_KEY, "K");
        add_item(OP_KEY, 8'hFF);
        add_item(OP_KEY, 8'h00);
        add_item(OP_DONE, 8'h00);
        // Encrypt: symbol pushed out of the square, extreme bytes, space
        add_item(OP_ENC, "9");
        add_item(OP_ENC, 8'hFF);
        add_item(OP_ENC, CH_SPACE);
        add_item(OP_ENC, 8'h00);
        // Decrypt: last cell, space clearing a held digit, bad digits
        add_item(OP_DEC, "5");
        add_item(OP_DEC, "5");
        add_item(OP_DEC, "5");
        add_item(OP_DEC, CH_SPACE);
        add_item(OP_DEC, "6");
        add_item(OP_DEC, 8'hFF);
        // Encrypt between the two digits of a pair keeps the held digit
        add_item(OP_DEC, "3");
        add_item(OP_ENC, CH_A);
        add_item(OP_DEC, "2");
        // Key done on a full square changes nothing
        add_item(OP_DONE, 8'hA5);
        n_directed = send_q.size();

        while (send_q.size() < n_directed + N_RANDOM) begin
            r = $urandom_range(0, 99);
            if (r < 60) begin
                // well-formed session: key, key done, message
                add_key(($urandom_range(0, 99) < 85) ? $urandom_range(0, 8)
                                                      : $urandom_range(30, 45));
                add_item(OP_DONE, 8'($urandom_range(0, 255)));
                if ($urandom_range(0, 9) == 0) add_item(OP_DONE, 8'($urandom_range(0, 255)));
                repeat ($urandom_range(4, 20)) add_text_step();
            end else if (r < 75) begin
                // partial square, no key done
                add_key($urandom_range(1, 12));
                repeat ($urandom_range(2, 8)) add_text_step();
            end else begin
                repeat ($urandom_range(3, 10))
                    add_item(2'($urandom_range(0, 3)), 8'($urandom_range(0, 255)));
            end
        end

        // Reset, then release at a falling edge
        repeat (10) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        while (send_q.size() != 0 || i_valid) @(posedge i_clk);
        while (cipher_results.size() != 0) @(posedge i_clk);
        repeat (DRAIN) @(posedge i_clk);

        if (cipher_results.size() != 0)
            report_mismatch($sformatf("%0d output characters never arrived",
                                      cipher_results.size()));
        $display("Took %0d transactions, checked %0d outputs in %0d cycles, %0d mismatches",
                 n_taken, n_results, cycle_cnt, mismatches);
        $display("  %0d enc pairs, %0d dec symbols, %0d spaces, %0d misses, %0d bad, %0d %s",
                 n_pairs, n_plain, n_space, n_miss, n_range, n_rekey,
                 $sformatf("rekeys, %0d key chars dropped on a full square", n_dropped));
        if (mismatches == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
sv/kpc_pkg.sv
sv/kpc_cell.sv
sv/keyed_polybius_cipher.sv
tb/tb.sv
